// ----- rtl/faf_pkg.sv -----
package faf_pkg;

	// Sizing of the block.
	localparam int NUM_CAMERAS    = 8;
	localparam int QUEUE_DEPTH    = 16;
	localparam int METADATA_LIMIT = 256 * 1024;

	// Cameras beyond the enable mask are never known.
	localparam int MASK_W      = 8;
	localparam int KNOWN_CAMS  = (NUM_CAMERAS < MASK_W) ? NUM_CAMERAS : MASK_W;
	localparam int CAM_W       = (KNOWN_CAMS > 1) ? $clog2(KNOWN_CAMS) : 1;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

	// Fixed field widths.
	localparam int FRAMES_W    = 5;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;

	// Operation codes.
	localparam logic [1:0] FUNC_SUBMIT  = 2'd0;
	localparam logic [1:0] FUNC_CLOSE   = 2'd1;
	localparam logic [1:0] FUNC_RELEASE = 2'd2;

	// Reason codes.
	localparam logic [3:0] RSN_OK      = 4'd0;
	localparam logic [3:0] RSN_CLOSED  = 4'd1;
	localparam logic [3:0] RSN_CAMERA  = 4'd2;
	localparam logic [3:0] RSN_BOUNDS  = 4'd3;
	localparam logic [3:0] RSN_META    = 4'd4;
	localparam logic [3:0] RSN_EPOCH   = 4'd5;
	localparam logic [3:0] RSN_SEQ     = 4'd6;
	localparam logic [3:0] RSN_PTS     = 4'd7;
	localparam logic [3:0] RSN_FULL    = 4'd8;
	localparam logic [3:0] RSN_EMPTY   = 4'd9;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_MASK = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAMES  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN     = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  camera;
		logic [31:0] source_epoch;
		logic [31:0] frame_sequence;
		logic [47:0] pts_us;
		logic [23:0] frame_bytes;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [23:0] metadata_bytes;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [3:0]  reason_code;
		logic [4:0]  frames_queued;
		logic [31:0] bytes_queued;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  camera_enable_mask;
		logic [4:0]  max_queued_frames;
		logic [31:0] max_queued_bytes;
		logic [23:0] max_frame_bytes;
	} cfg_t;

	// Classified item handed from the front end to the back end.
	typedef struct packed {
		logic [1:0]       func;
		logic [3:0]       static_reason;
		logic [CAM_W-1:0] cam;
		logic [31:0]      epoch;
		logic [31:0]      seq;
		logic [47:0]      pts;
		logic [23:0]      len;
	} cmd_t;

endpackage

// ----- rtl/faf_front.sv -----
module faf_front (
	input  faf_pkg::req_t req,
	input  faf_pkg::cfg_t cfg,
	output faf_pkg::cmd_t cmd
);
	import faf_pkg::*;

	logic cam_known;
	logic bounds_bad;
	logic meta_bad;

	// Checks that need nothing but the item and the configuration.
	always_comb begin
		cam_known  = (32'(req.camera) < 32'(KNOWN_CAMS)) &&
		             cfg.camera_enable_mask[req.camera[2:0]];
		bounds_bad = (req.source_epoch == 32'd0) || (req.frame_bytes == 24'd0) ||
		             (req.frame_bytes > cfg.max_frame_bytes) ||
		             (req.frame_width == 16'd0) || (req.frame_height == 16'd0);
		meta_bad   = 32'(req.metadata_bytes) > 32'(METADATA_LIMIT);

		cmd.func  = req.func;
		cmd.cam   = req.camera[CAM_W-1:0];
		cmd.epoch = req.source_epoch;
		cmd.seq   = req.frame_sequence;
		cmd.pts   = req.pts_us;
		cmd.len   = req.frame_bytes;
		if (!cam_known) begin
			cmd.static_reason = RSN_CAMERA;
		end else if (bounds_bad) begin
			cmd.static_reason = RSN_BOUNDS;
		end else if (meta_bad) begin
			cmd.static_reason = RSN_META;
		end else begin
			cmd.static_reason = RSN_OK;
		end
	end

endmodule

// ----- rtl/faf_queue.sv -----
module faf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  faf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output faf_pkg::cmd_t head_cmd
);
	import faf_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/faf_back.sv -----
module faf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  faf_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  faf_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output faf_pkg::rsp_t rsp
);
	import faf_pkg::*;

	typedef enum logic {
		S_FETCH,
		S_EXEC
	} state_t;

	state_t state_q;
	cmd_t   item_q;
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	logic                closed_q;
	logic [KNOWN_CAMS-1:0] epoch_seen_q;
	logic [KNOWN_CAMS-1:0] hist_seen_q;
	logic [31:0]         epoch_tab_q [KNOWN_CAMS];
	logic [31:0]         seq_tab_q   [KNOWN_CAMS];
	logic [47:0]         pts_tab_q   [KNOWN_CAMS];

	logic [23:0]         len_mem [QUEUE_DEPTH];
	logic [23:0]         head_len_q;
	logic [QPTR_W-1:0]   head_q;
	logic [QPTR_W-1:0]   tail_q;
	logic [COUNT_W-1:0]  count_q;
	logic [31:0]         total_q;

	logic               commit;
	logic               ok;
	logic [3:0]         reason;
	logic               do_push;
	logic               do_pop;
	logic               do_close;
	logic               rec_epoch;
	logic               queue_full;
	logic [COUNT_W-1:0] count_nx;
	logic [31:0]        total_nx;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (32'(p) == QUEUE_DEPTH - 1) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	assign cmd_pop   = (state_q == S_FETCH) && cmd_valid;
	assign commit    = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		queue_full = (32'(count_q) >= 32'(cfg.max_queued_frames)) ||
		             (32'(count_q) >= QUEUE_DEPTH) ||
		             ({1'b0, total_q} + 33'(item_q.len) > {1'b0, cfg.max_queued_bytes});
		ok        = 1'b0;
		reason    = RSN_OK;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_close  = 1'b0;
		rec_epoch = 1'b0;
		case (item_q.func)
			FUNC_SUBMIT: begin
				if (closed_q) begin
					reason = RSN_CLOSED;
				end else if (item_q.static_reason != RSN_OK) begin
					reason = item_q.static_reason;
				end else if (epoch_seen_q[item_q.cam] &&
				             epoch_tab_q[item_q.cam] != item_q.epoch) begin
					reason = RSN_EPOCH;
				end else begin
					rec_epoch = 1'b1;
					if (hist_seen_q[item_q.cam] && item_q.seq <= seq_tab_q[item_q.cam]) begin
						reason = RSN_SEQ;
					end else if (hist_seen_q[item_q.cam] &&
					             item_q.pts < pts_tab_q[item_q.cam]) begin
						reason = RSN_PTS;
					end else if (queue_full) begin
						reason = RSN_FULL;
					end else begin
						do_push = 1'b1;
						ok      = 1'b1;
					end
				end
			end
			FUNC_CLOSE: begin
				do_close = 1'b1;
				ok       = 1'b1;
			end
			FUNC_RELEASE: begin
				if (count_q == '0) begin
					reason = RSN_EMPTY;
				end else begin
					do_pop = 1'b1;
					ok     = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (do_push) begin
			count_nx = count_q + COUNT_W'(1);
			total_nx = total_q + 32'(item_q.len);
		end else if (do_pop) begin
			count_nx = count_q - COUNT_W'(1);
			total_nx = total_q - 32'(head_len_q);
		end else begin
			count_nx = count_q;
			total_nx = total_q;
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FETCH;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_FETCH: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
					if (rsp_valid_q && !rsp_stall) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q     <= S_FETCH;
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{accepted: ok, reason_code: reason,
						                 frames_queued: FRAMES_W'(count_nx),
						                 bytes_queued: total_nx};
					end
				end
				default: begin
					state_q <= S_FETCH;
				end
			endcase
		end
	end

	// Control state of the admission tables and the length queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q     <= 1'b0;
			epoch_seen_q <= '0;
			hist_seen_q  <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			total_q      <= '0;
		end else if (commit) begin
			if (do_close) begin
				closed_q <= 1'b1;
			end
			if (rec_epoch) begin
				epoch_seen_q[item_q.cam] <= 1'b1;
			end
			if (do_push) begin
				hist_seen_q[item_q.cam] <= 1'b1;
				tail_q <= ptr_inc(tail_q);
			end
			if (do_pop) begin
				head_q <= ptr_inc(head_q);
			end
			count_q <= count_nx;
			total_q <= total_nx;
		end
	end

	// Fetched item register and per-camera payload tables; the tables are meaningful only once their seen bit is set.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			item_q <= cmd;
		end
		if (commit && rec_epoch) begin
			epoch_tab_q[item_q.cam] <= item_q.epoch;
		end
		if (commit && do_push) begin
			seq_tab_q[item_q.cam] <= item_q.seq;
			pts_tab_q[item_q.cam] <= item_q.pts;
		end
	end

	// Length memory: one write port at the tail, one registered read at the head.
	always_ff @(posedge clk) begin
		if (commit && do_push) begin
			len_mem[tail_q] <= item_q.len;
		end
		head_len_q <= len_mem[head_q];
	end

endmodule

// ----- rtl/frame_admission_filter.sv -----
// Frame admission filter: checks camera frame descriptors against per-camera history and queue limits.
// An accepted item passes the two-entry queue, then the back end's fetch and execute steps, which wrap
// the registered read of the length memory; the back end takes no new item until the previous result
// is committed, which a stalled result holds up, while the queue lets input run ahead of it.
// Reset (arst_n, asynchronous, active low) opens ingress, clears all seen bits, empties the
// length queue and restores the configuration registers to their defaults; no clearing pass.
module frame_admission_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  faf_pkg::req_t                       req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output faf_pkg::rsp_t                       rsp,
	input  logic                                cfg_we,
	input  logic [faf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [faf_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import faf_pkg::*;

	// Configuration registers. They are to be written only while the block is idle, so that both
	// halves of the design can read them without any hand-off; the block itself does not enforce this.
	cfg_t cfg_q;

	// Front end output, queue status and the classified item at the queue head.
	cmd_t front_cmd;
	cmd_t head_cmd;
	logic queue_full;
	logic head_valid;
	logic head_pop;
	logic push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_enable_mask <= 8'hFF;
			cfg_q.max_queued_frames  <= 5'd16;
			cfg_q.max_queued_bytes   <= 32'hFFFF_FFFF;
			cfg_q.max_frame_bytes    <= 24'hFF_FFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAMERA_MASK: cfg_q.camera_enable_mask <= cfg_data[7:0];
				CFG_MAX_FRAMES:  cfg_q.max_queued_frames  <= cfg_data[4:0];
				CFG_MAX_BYTES:   cfg_q.max_queued_bytes   <= cfg_data;
				CFG_MAX_LEN:     cfg_q.max_frame_bytes    <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	// An item is taken whenever the queue has room; the stall is the queue's
	// full flag and nothing more.
	assign req_stall = queue_full;
	assign push      = req_valid && !queue_full;

	// The front end runs the checks that depend only on the item and the
	// configuration: camera known, length and size bounds, metadata limit.
	faf_front u_front (
		.req (req),
		.cfg (cfg_q),
		.cmd (front_cmd)
	);

	faf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (front_cmd),
		.full       (queue_full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// The back end owns all item-to-item state: the closed flag, the epoch,
	// sequence and time tables, the length memory and the running totals. It
	// resolves the ordered checks and drives the result register.
	faf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (head_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import faf_pkg::*;

	// The fourth function code has no name in the package; the block ignores it.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int LIMIT_PHASES    = 8;
	localparam int ITEMS_PER_PHASE = 190;

	// One row of the directed stimulus. When pinned is set, the expected result is
	// the one typed into the row rather than the one the predictor works out.
	typedef struct {
		req_t item;
		bit   pinned;
		rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	frame_admission_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Shadow of the block's limits and of its admission state, kept in step with
	// every item the block accepts.
	logic [7:0]             lim_mask;
	logic [4:0]             lim_frames;
	logic [31:0]            lim_bytes;
	logic [23:0]            lim_len;
	logic                   shut;
	logic [NUM_CAMERAS-1:0] epoch_known;
	logic [NUM_CAMERAS-1:0] hist_known;
	logic [31:0]            epoch_of [NUM_CAMERAS];
	logic [31:0]            last_seq [NUM_CAMERAS];
	logic [47:0]            last_pts [NUM_CAMERAS];
	logic [23:0]            len_ring [QUEUE_DEPTH];
	logic [4:0]             held_count;
	int                     ring_head;
	logic [31:0]            held_bytes;

	// What the stimulus plans to send next for each camera, so that most submits
	// carry the right epoch and a rising sequence and time.
	logic [31:0] plan_epoch [NUM_CAMERAS];
	logic [31:0] plan_seq   [NUM_CAMERAS];
	logic [47:0] plan_pts   [NUM_CAMERAS];

	rsp_t verdicts_due [$];
	row_t opening [$];
	row_t closing [$];
	int   mismatches = 0;
	bit   steady;
	bit   pin_now;
	rsp_t pin_rsp;
	rsp_t guess;
	rsp_t want;
	rsp_t got;

	// Works out the result of one item and moves the shadow state on. The submit
	// checks run in the block's fixed order; the first one that fails names the
	// reason. The epoch is recorded as soon as the epoch check passes, while the
	// sequence and time only move on acceptance.
	function automatic rsp_t admission_verdict(req_t r);
		rsp_t       v;
		logic [3:0] why;
		logic       ok;
		int         c;
		why = RSN_OK;
		ok  = 1'b0;
		case (r.func)
			FUNC_SUBMIT: begin
				if (shut) begin
					why = RSN_CLOSED;
				end else if (r.camera >= KNOWN_CAMS || !lim_mask[r.camera[2:0]]) begin
					why = RSN_CAMERA;
				end else begin
					c = int'(r.camera);
					if (r.source_epoch == '0 || r.frame_bytes == '0 || r.frame_bytes > lim_len ||
					    r.frame_width == '0 || r.frame_height == '0) begin
						why = RSN_BOUNDS;
					end else if (r.metadata_bytes > METADATA_LIMIT) begin
						why = RSN_META;
					end else if (epoch_known[c] && epoch_of[c] != r.source_epoch) begin
						why = RSN_EPOCH;
					end else begin
						epoch_known[c] = 1'b1;
						epoch_of[c]    = r.source_epoch;
						if (hist_known[c] && r.frame_sequence <= last_seq[c]) begin
							why = RSN_SEQ;
						end else if (hist_known[c] && r.pts_us < last_pts[c]) begin
							why = RSN_PTS;
						end else if (held_count >= lim_frames || held_count >= QUEUE_DEPTH ||
						             {1'b0, held_bytes} + 33'(r.frame_bytes) >
						             {1'b0, lim_bytes}) begin
							why = RSN_FULL;
						end else begin
							hist_known[c] = 1'b1;
							last_seq[c]   = r.frame_sequence;
							last_pts[c]   = r.pts_us;
							len_ring[(ring_head + held_count) % QUEUE_DEPTH] = r.frame_bytes;
							held_count++;
							held_bytes += 32'(r.frame_bytes);
							ok = 1'b1;
						end
					end
				end
			end
			FUNC_CLOSE: begin
				shut = 1'b1;
				ok   = 1'b1;
			end
			FUNC_RELEASE: begin
				// The consumer may still drain the queue after ingress is closed.
				if (held_count == '0) begin
					why = RSN_EMPTY;
				end else begin
					held_bytes -= 32'(len_ring[ring_head]);
					ring_head = (ring_head + 1) % QUEUE_DEPTH;
					held_count--;
					ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		v.accepted      = ok;
		v.reason_code   = why;
		v.frames_queued = held_count;
		v.bytes_queued  = held_bytes;
		return v;
	endfunction

	function automatic req_t desc(logic [1:0] fn, logic [7:0] cam, logic [31:0] epoch,
	                              logic [31:0] seq, logic [47:0] pts, logic [23:0] len,
	                              logic [15:0] wid, logic [15:0] hgt, logic [23:0] meta);
		req_t r;
		r.func           = fn;
		r.camera         = cam;
		r.source_epoch   = epoch;
		r.frame_sequence = seq;
		r.pts_us         = pts;
		r.frame_bytes    = len;
		r.frame_width    = wid;
		r.frame_height   = hgt;
		r.metadata_bytes = meta;
		return r;
	endfunction

	function automatic rsp_t pin(logic ok, logic [3:0] why, logic [4:0] frames,
	                             logic [31:0] bytes);
		rsp_t v;
		v.accepted      = ok;
		v.reason_code   = why;
		v.frames_queued = frames;
		v.bytes_queued  = bytes;
		return v;
	endfunction

	// Builds one random item. Most submits are well formed for their camera, so
	// that they reach the sequence, time and queue checks; about a fifth are broken
	// on purpose at one check, and a few are pure noise across every bit.
	function automatic req_t next_random_item(int rel_pct);
		req_t         r;
		logic [223:0] noise;
		int           c;
		int           roll;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r     = noise[$bits(req_t)-1:0];
		roll  = $urandom_range(0, 99);
		if (roll < 3) begin
			r.func = FUNC_UNUSED;
			return r;
		end
		if (roll < 3 + rel_pct) begin
			r.func = FUNC_RELEASE;
			return r;
		end
		r.func = FUNC_SUBMIT;
		if ($urandom_range(0, 99) < 6)
			return r;
		c = $urandom_range(0, NUM_CAMERAS - 1);
		r.camera         = 8'(c);
		r.source_epoch   = plan_epoch[c];
		plan_seq[c]     += $urandom_range(1, 4);
		r.frame_sequence = plan_seq[c];
		plan_pts[c]     += $urandom_range(0, 900);
		r.pts_us         = plan_pts[c];
		r.frame_width    = 16'($urandom_range(1, 16'hFFFF));
		r.frame_height   = 16'($urandom_range(1, 16'hFFFF));
		r.metadata_bytes = 24'($urandom_range(0, METADATA_LIMIT));
		// Mostly small frames so that many fit, sometimes anything up to the limit.
		roll = $urandom_range(0, 9);
		if (lim_len == '0)
			r.frame_bytes = 24'($urandom_range(1, 4096));
		else if (roll < 7)
			r.frame_bytes = 24'($urandom_range(1, (lim_len < 2048) ? lim_len : 2048));
		else if (roll < 9)
			r.frame_bytes = 24'($urandom_range(1, lim_len));
		else
			r.frame_bytes = lim_len;
		if ($urandom_range(0, 99) < 20) begin
			case ($urandom_range(0, 7))
				0: r.source_epoch = plan_epoch[c] + $urandom_range(1, 1000);
				1: r.frame_sequence = plan_seq[c] - $urandom_range(4, 12);
				2: begin
					if (plan_pts[c] > 48'd3000)
						r.pts_us = plan_pts[c] - $urandom_range(1000, 3000);
				end
				3: begin
					if ($urandom_range(0, 1))
						r.frame_width = '0;
					else
						r.frame_height = '0;
				end
				4: begin
					if (lim_len != 24'hFFFFFF)
						r.frame_bytes = 24'($urandom_range(32'(lim_len) + 1, 24'hFFFFFF));
				end
				5: r.metadata_bytes = 24'($urandom_range(METADATA_LIMIT + 1, 24'hFFFFFF));
				6: r.camera = 8'($urandom_range(8, 255));
				default: begin
					if ($urandom_range(0, 1))
						r.source_epoch = '0;
					else
						r.frame_bytes = '0;
				end
			endcase
		end
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Offers one item and returns at the edge that accepts it. The valid line is
	// left high; the next offer or a settle decides what it does next.
	task automatic offer(req_t it, bit pinned, rsp_t pinned_rsp);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 22) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		pin_now    = pinned;
		pin_rsp    = pinned_rsp;
		do @(posedge clk); while (req_stall);
	endtask

	// Stops offering, waits for every outstanding result, then idles before returning.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic poke(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
	endtask

	// Writes all four limits while the block is idle and mirrors them.
	task automatic set_limits(logic [7:0] mask, logic [4:0] frames, logic [31:0] bytes,
	                          logic [23:0] len);
		poke(CFG_CAMERA_MASK, 32'(mask));
		poke(CFG_MAX_FRAMES, 32'(frames));
		poke(CFG_MAX_BYTES, bytes);
		poke(CFG_MAX_LEN, 32'(len));
		@(negedge clk);
		cfg_we <= 1'b0;
		lim_mask   = mask;
		lim_frames = frames;
		lim_bytes  = bytes;
		lim_len    = len;
	endtask

	// The consumer stalls at random, except during the steady phase.
	always @(negedge clk)
		rsp_stall <= !steady && ($urandom_range(0, 99) < 22);

	// Every accepted item gets its expected result queued here, and every result
	// that leaves the block is checked against the oldest one. The push comes first,
	// so the order within one edge never matters.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (req_valid && !req_stall) begin
				guess = admission_verdict(req);
				verdicts_due.insert(verdicts_due.size(), pin_now ? pin_rsp : guess);
			end
			if (rsp_valid && !rsp_stall) begin
				got = rsp;
				if (verdicts_due.size() == 0) begin
					flag_mismatch("result offered with no item outstanding");
				end else begin
					want = verdicts_due.pop_front();
					if (got.accepted !== want.accepted)
						flag_mismatch($sformatf("accepted got %0b want %0b",
							got.accepted, want.accepted));
					if (got.reason_code !== want.reason_code)
						flag_mismatch($sformatf("reason_code got %0d want %0d",
							got.reason_code, want.reason_code));
					if (got.frames_queued !== want.frames_queued)
						flag_mismatch($sformatf("frames_queued got %0d want %0d",
							got.frames_queued, want.frames_queued));
					if (got.bytes_queued !== want.bytes_queued)
						flag_mismatch($sformatf("bytes_queued got %0d want %0d",
							got.bytes_queued, want.bytes_queued));
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_CAMERA_MASK;
		cfg_data  = '0;
		steady    = 1'b0;
		pin_now   = 1'b0;
		pin_rsp   = '0;

		// Shadow state after reset: open, nothing seen, queue empty, limits at
		// their widest.
		lim_mask    = 8'hFF;
		lim_frames  = 5'd16;
		lim_bytes   = 32'hFFFF_FFFF;
		lim_len     = 24'hFF_FFFF;
		shut        = 1'b0;
		epoch_known = '0;
		hist_known  = '0;
		held_count  = '0;
		ring_head   = 0;
		held_bytes  = '0;
		for (int k = 0; k < NUM_CAMERAS; k++) begin
			epoch_of[k] = '0;
			last_seq[k] = '0;
			last_pts[k] = '0;
		end
		for (int k = 0; k < QUEUE_DEPTH; k++)
			len_ring[k] = '0;

		// Directed rows, run right after reset with the default limits. The queue
		// contents are easy to follow here, so most rows carry their result.
		opening.insert(opening.size(), '{desc(FUNC_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			pin(1'b0, RSN_EMPTY, 0, 0)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 8, 1, 0, 0, 1, 1, 1, 0), 1,
			pin(1'b0, RSN_CAMERA, 0, 0)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 8'hFF, 1, 0, 0, 1, 1, 1, 0), 1,
			pin(1'b0, RSN_CAMERA, 0, 0)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 0, 0, 0, 0, 1, 1, 1, 0), 1,
			pin(1'b0, RSN_BOUNDS, 0, 0)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 0, 1, 0, 0, 0, 1, 1, 0), 1,
			pin(1'b0, RSN_BOUNDS, 0, 0)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 0, 1, 0, 0, 1, 0, 1, 0), 1,
			pin(1'b0, RSN_BOUNDS, 0, 0)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 0, 1, 0, 0, 1, 1, 0, 0), 1,
			pin(1'b0, RSN_BOUNDS, 0, 0)});
		// All fields at their top; only the metadata is one byte over the limit,
		// so the epoch of camera seven is not recorded.
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 24'(METADATA_LIMIT + 1)), 1,
			pin(1'b0, RSN_META, 0, 0)});
		// Metadata exactly at the limit and the smallest sizes are accepted.
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 0, 1, 0, 0, 1, 1, 1,
			24'(METADATA_LIMIT)), 1, pin(1'b1, RSN_OK, 1, 1)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 0, 2, 1, 0, 1, 1, 1, 0), 1,
			pin(1'b0, RSN_EPOCH, 1, 1)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 0, 1, 0, 0, 1, 1, 1, 0), 1,
			pin(1'b0, RSN_SEQ, 1, 1)});
		// Equal time is allowed; the largest frame is accepted.
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 0, 1, 1, 0, 24'hFF_FFFF, 1, 1, 0),
			1, pin(1'b1, RSN_OK, 2, 32'h0100_0000)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 7, 32'hFFFF_FFFF, 100, 100, 16,
			16'hFFFF, 16'hFFFF, 0), 1, pin(1'b1, RSN_OK, 3, 32'h0100_0010)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 7, 32'hFFFF_FFFF, 101, 99, 16, 1,
			1, 0), 1, pin(1'b0, RSN_PTS, 3, 32'h0100_0010)});
		opening.insert(opening.size(), '{desc(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF,
			24'hFF_FFFF), 1, pin(1'b0, RSN_OK, 3, 32'h0100_0010)});
		opening.insert(opening.size(), '{desc(FUNC_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			pin(1'b1, RSN_OK, 2, 32'h0100_000F)});
		opening.insert(opening.size(), '{desc(FUNC_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			pin(1'b1, RSN_OK, 1, 16)});
		opening.insert(opening.size(), '{desc(FUNC_SUBMIT, 1, 5, 0, 0, 100, 640, 480, 0), 0,
			'0});

		// Closing rows: ingress is closed for good, so they come last. Submits are
		// refused, a second close still succeeds, and releases drain the queue
		// until one finds it empty.
		closing.insert(closing.size(), '{desc(FUNC_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
		closing.insert(closing.size(), '{desc(FUNC_SUBMIT, 2, 9, 9, 9, 9, 9, 9, 0), 0, '0});
		closing.insert(closing.size(), '{desc(FUNC_CLOSE, 8'hFF, 0, 0, 0, 0, 0, 0, 0), 0,
			'0});
		repeat (QUEUE_DEPTH + 1)
			closing.insert(closing.size(), '{desc(FUNC_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0), 0,
				'0});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening[i])
			offer(opening[i].item, opening[i].pinned, opening[i].want);

		for (int k = 0; k < NUM_CAMERAS; k++) begin
			plan_epoch[k] = $urandom_range(1, 32'hFFFF_FFFF);
			plan_seq[k]   = $urandom_range(0, 1000);
			plan_pts[k]   = $urandom_range(5000, 100000);
		end

		// Random phases, each under its own set of limits. The block is drained
		// before every write, which also makes the sender wait for every result.
		for (int ph = 0; ph < LIMIT_PHASES; ph++) begin
			settle();
			// Pick up whatever the block really recorded, so that well-formed
			// submits stay well formed after a stray one was accepted.
			for (int k = 0; k < NUM_CAMERAS; k++) begin
				if (epoch_known[k])
					plan_epoch[k] = epoch_of[k];
				if (hist_known[k] && last_seq[k] < 32'hF000_0000 &&
				    last_pts[k] < 48'hF000_0000_0000) begin
					plan_seq[k] = last_seq[k];
					plan_pts[k] = last_pts[k];
				end
			end
			case (ph)
				0: set_limits(8'hFF, 5'd16, 32'hFFFF_FFFF, 24'hFF_FFFF);
				1: set_limits(8'h01, 5'd1, 32'd1, 24'd1);
				2: set_limits(8'($urandom_range(1, 255)), 5'd4, 32'd6000, 24'd2000);
				// A frame limit above the queue depth still stops at the depth.
				3: set_limits(8'hA5, 5'd24, 32'd100000, 24'd65535);
				// A frame limit of zero makes every submit that passes the earlier checks find the queue full.
				4: set_limits(8'h0F, 5'd0, 32'hFFFF_FFFF, 24'd4096);
				// A length limit of zero fails every submit past the camera check on its bounds.
				5: set_limits(8'hF0, 5'd8, 32'd20000, 24'd0);
				6: set_limits(8'($urandom_range(1, 255)), 5'($urandom_range(1, 16)), $urandom,
					24'($urandom_range(1, 24'hFF_FFFF)));
				default: set_limits(8'hFF, 5'd16, 32'd50000000, 24'hFF_FFFF);
			endcase
			// One whole phase runs with neither side idling.
			steady = (ph == 3);
			begin
				int rel_pct;
				rel_pct = $urandom_range(28, 50);
				repeat (ITEMS_PER_PHASE) begin
					offer(next_random_item(rel_pct), 1'b0, '0);
					if ($urandom_range(0, 149) == 0)
						settle();
				end
			end
		end

		settle();
		steady = 1'b0;
		foreach (closing[i])
			offer(closing[i].item, closing[i].pinned, closing[i].want);
		settle();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// A correct run takes well under a tenth of this.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
